FILE: rtl/olxf_pkg.sv
// ----------------------------------------------------------------------------
// olxf_pkg
// shared types and constants for the opcode/length/xor message framer
// ----------------------------------------------------------------------------
package olxf_pkg;

  typedef enum logic [2:0] {
    StOk      = 3'd0,
    StBadXor  = 3'd1,
    StCutOff  = 3'd2,
    StStray   = 3'd3,
    StTooLong = 3'd4
  } status_e;

  // event from the receive side to the output side, valid on an accepted byte
  typedef struct packed {
    logic    err;
    status_e status;
    logic    done;
  } rx_evt_t;

  localparam logic [7:0] OpcodeMin = 8'h80;
  localparam logic [7:0] SelMask   = 8'h60;
  localparam int         SelShift  = 5;
  localparam logic [6:0] LongMask  = 7'h7F;
  localparam logic [7:0] XorGood   = 8'hFF;

  localparam logic [1:0] SelLen2 = 2'd0;
  localparam logic [1:0] SelLen4 = 2'd1;
  localparam logic [1:0] SelLen6 = 2'd2;

  localparam logic [7:0] Len2 = 8'd2;
  localparam logic [7:0] Len4 = 8'd4;
  localparam logic [7:0] Len6 = 8'd6;

  localparam int MsgByteW = 8;
  localparam int IndexW   = 6;

endpackage

FILE: rtl/opcode_length_xor_framer.sv
// ----------------------------------------------------------------------------
// opcode_length_xor_framer
// frames received serial bytes into opcode-led messages with an xor check
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                          | tuser     | tlast
//  s_axis   | in  | [7:0] rx_byte                  | -         | -
//  m_axis   | out | [7:0] msg_byte, [13:8] byte_index | [2:0] status | last
//
//  one input byte is taken per cycle while no message is being read out and m_axis is not stalled
//  a good message is read from the store at one byte per cycle after the
//  closing byte while m_axis is not stalled, one store read port sets that rate
//  error results go straight to the result register and the next byte is taken alongside
//  reset clears the framing state; the store needs no clearing
//  m_axis_tready low holds a waiting result in its register and stops input
// ----------------------------------------------------------------------------
module opcode_length_xor_framer #(
  parameter int MAX_MESSAGE_BYTES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] msg_byte, [13:8] byte_index, [15:14] zero
  output logic [2:0]  m_axis_tuser,   // [2:0] status
  output logic        m_axis_tlast
);
  import olxf_pkg::*;

  localparam int AddrW = $clog2(MAX_MESSAGE_BYTES);
  localparam int CntW  = $clog2(MAX_MESSAGE_BYTES + 1);

  logic              acc;
  logic              we;
  logic [AddrW-1:0]  waddr;
  logic [7:0]        wdata;
  logic              re;
  logic [AddrW-1:0]  raddr;
  logic [7:0]        rdata;
  rx_evt_t           evt;
  logic [CntW-1:0]   len;
  logic [MsgByteW-1:0] ob;
  logic [IndexW-1:0] oi;
  status_e           os;

  assign acc = s_axis_tvalid && s_axis_tready;

  olxf_rx #(
    .MaxBytes (MAX_MESSAGE_BYTES),
    .AddrW    (AddrW),
    .CntW     (CntW)
  ) u_rx (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .acc_i   (acc),
    .byte_i  (s_axis_tdata),
    .we_o    (we),
    .waddr_o (waddr),
    .wdata_o (wdata),
    .evt_o   (evt),
    .len_o   (len)
  );

  olxf_store #(
    .Depth (MAX_MESSAGE_BYTES),
    .AddrW (AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  olxf_drain #(
    .AddrW (AddrW),
    .CntW  (CntW)
  ) u_drain (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .evt_i        (evt),
    .len_i        (len),
    .in_ready_o   (s_axis_tready),
    .re_o         (re),
    .raddr_o      (raddr),
    .rdata_i      (rdata),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_byte_o   (ob),
    .out_index_o  (oi),
    .out_last_o   (m_axis_tlast),
    .out_status_o (os)
  );

  assign m_axis_tdata = {2'b00, oi, ob};
  assign m_axis_tuser = os;

endmodule

FILE: rtl/olxf_store.sv
// ----------------------------------------------------------------------------
// olxf_store
// message byte memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module olxf_store #(
  parameter int Depth = 32,
  parameter int AddrW = 5
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem_q [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/olxf_rx.sv
// ----------------------------------------------------------------------------
// olxf_rx
// receive side: length decode, byte count, running xor and store writes
// ----------------------------------------------------------------------------
module olxf_rx #(
  parameter int MaxBytes = 32,
  parameter int AddrW    = 5,
  parameter int CntW     = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                acc_i,
  input  logic [7:0]          byte_i,
  output logic                we_o,
  output logic [AddrW-1:0]    waddr_o,
  output logic [7:0]          wdata_o,
  output olxf_pkg::rx_evt_t   evt_o,
  output logic [CntW-1:0]     len_o
);
  import olxf_pkg::*;

  logic            coll_q, coll_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]      exp_q, exp_d;
  logic            longp_q, longp_d;
  logic [7:0]      xor_q, xor_d;
  logic [1:0]      sel;
  logic [CntW-1:0] cnt_inc;
  logic            is_full;

  assign sel     = 2'((byte_i & SelMask) >> SelShift);
  assign cnt_inc = cnt_q + CntW'(1);
  assign is_full = (cnt_q >= CntW'(MaxBytes));

  always_comb begin
    coll_d  = coll_q;
    cnt_d   = cnt_q;
    exp_d   = exp_q;
    longp_d = longp_q;
    xor_d   = xor_q;
    we_o    = 1'b0;
    waddr_o = cnt_q[AddrW-1:0];
    wdata_o = byte_i;
    evt_o   = '{err: 1'b0, status: StOk, done: 1'b0};
    len_o   = cnt_inc;
    if (acc_i) begin
      if (byte_i >= OpcodeMin) begin
        if (coll_q) begin
          evt_o.err    = 1'b1;
          evt_o.status = StCutOff;
        end
        coll_d  = 1'b1;
        longp_d = 1'b0;
        case (sel)
          SelLen2: exp_d = Len2;
          SelLen4: exp_d = Len4;
          SelLen6: exp_d = Len6;
          default: begin
            exp_d   = '0;
            longp_d = 1'b1;
          end
        endcase
        xor_d   = byte_i;
        we_o    = 1'b1;
        waddr_o = '0;
        cnt_d   = CntW'(1);
      end else if (!coll_q) begin
        evt_o.err    = 1'b1;
        evt_o.status = StStray;
      end else if (is_full) begin
        evt_o.err    = 1'b1;
        evt_o.status = StTooLong;
        coll_d       = 1'b0;
        cnt_d        = '0;
        longp_d      = 1'b0;
      end else begin
        we_o = 1'b1;
        if (cnt_q == CntW'(1) && longp_q) begin
          exp_d   = {1'b0, byte_i[6:0] & LongMask};
          longp_d = 1'b0;
        end
        cnt_d = cnt_inc;
        xor_d = xor_q ^ byte_i;
        if (!longp_d && (8'(cnt_inc) == exp_d)) begin
          if (xor_d == XorGood) begin
            evt_o.done = 1'b1;
          end else begin
            evt_o.err    = 1'b1;
            evt_o.status = StBadXor;
          end
          coll_d  = 1'b0;
          cnt_d   = '0;
          longp_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coll_q  <= 1'b0;
      cnt_q   <= '0;
      exp_q   <= '0;
      longp_q <= 1'b0;
      xor_q   <= '0;
    end else begin
      coll_q  <= coll_d;
      cnt_q   <= cnt_d;
      exp_q   <= exp_d;
      longp_q <= longp_d;
      xor_q   <= xor_d;
    end
  end

endmodule

FILE: rtl/olxf_drain.sv
// ----------------------------------------------------------------------------
// olxf_drain
// output side: error results and read-out of a checked message from the store
// ----------------------------------------------------------------------------
module olxf_drain #(
  parameter int AddrW = 5,
  parameter int CntW  = 6
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  olxf_pkg::rx_evt_t                 evt_i,
  input  logic [CntW-1:0]                   len_i,
  output logic                              in_ready_o,
  output logic                              re_o,
  output logic [AddrW-1:0]                  raddr_o,
  input  logic [7:0]                        rdata_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [olxf_pkg::MsgByteW-1:0]     out_byte_o,
  output logic [olxf_pkg::IndexW-1:0]       out_index_o,
  output logic                              out_last_o,
  output olxf_pkg::status_e                 out_status_o
);
  import olxf_pkg::*;

  typedef enum logic [1:0] {
    DrIdle = 2'b01,
    DrBusy = 2'b10
  } drain_state_e;

  drain_state_e     state_q, state_d;
  logic [CntW-1:0]  len_q, len_d;
  logic [CntW-1:0]  rd_ptr_q, rd_ptr_d;
  logic             pend_q, pend_d;
  logic [AddrW-1:0] pend_idx_q, pend_idx_d;
  logic             ov_q, ov_d;
  logic [7:0]       ob_q, ob_d;
  logic [IndexW-1:0] oi_q, oi_d;
  logic             ol_q, ol_d;
  status_e          os_q, os_d;
  logic             out_free;
  logic             load;
  logic             busy;

  assign busy       = (state_q == DrBusy);
  assign out_free   = !ov_q || out_ready_i;
  assign in_ready_o = (state_q == DrIdle) && out_free;
  assign load       = busy && pend_q && out_free;
  assign re_o       = busy && (rd_ptr_q < len_q) && (!pend_q || load);
  assign raddr_o    = rd_ptr_q[AddrW-1:0];

  always_comb begin
    state_d    = state_q;
    len_d      = len_q;
    rd_ptr_d   = rd_ptr_q;
    pend_d     = pend_q;
    pend_idx_d = pend_idx_q;
    ov_d       = ov_q && !out_ready_i;
    ob_d       = ob_q;
    oi_d       = oi_q;
    ol_d       = ol_q;
    os_d       = os_q;
    case (state_q)
      DrIdle: begin
        if (evt_i.err) begin
          ov_d = 1'b1;
          ob_d = '0;
          oi_d = '0;
          ol_d = 1'b1;
          os_d = evt_i.status;
        end
        if (evt_i.done) begin
          state_d  = DrBusy;
          len_d    = len_i;
          rd_ptr_d = '0;
          pend_d   = 1'b0;
        end
      end
      DrBusy: begin
        if (load) begin
          ov_d   = 1'b1;
          ob_d   = rdata_i;
          oi_d   = IndexW'(pend_idx_q);
          ol_d   = ((CntW'(pend_idx_q) + CntW'(1)) == len_q);
          os_d   = StOk;
          pend_d = 1'b0;
        end
        if (re_o) begin
          pend_d     = 1'b1;
          pend_idx_d = rd_ptr_q[AddrW-1:0];
          rd_ptr_d   = rd_ptr_q + CntW'(1);
        end
        if (!pend_q && (rd_ptr_q == len_q)) begin
          state_d = DrIdle;
        end
      end
      default: state_d = DrIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= DrIdle;
      len_q    <= '0;
      rd_ptr_q <= '0;
      pend_q   <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      len_q    <= len_d;
      rd_ptr_q <= rd_ptr_d;
      pend_q   <= pend_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q <= pend_idx_d;
    ob_q       <= ob_d;
    oi_q       <= oi_d;
    ol_q       <= ol_d;
    os_q       <= os_d;
  end

  assign out_valid_o  = ov_q;
  assign out_byte_o   = ob_q;
  assign out_index_o  = oi_q;
  assign out_last_o   = ol_q;
  assign out_status_o = os_q;

`ifndef NO_ASSERTIONS
  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && os_q != StOk) |-> (ol_q && ob_q == '0 && oi_q == '0))
    else $error("error result without last flag or with payload");

  a_pend_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> busy)
    else $error("store read pending outside message read-out");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !in_ready_o)
    else $error("input ready during message read-out");

  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> (rd_ptr_q <= len_q))
    else $error("read pointer ran past message length");
`endif

endmodule
